### hw/rtl/cfsp_pkg.sv
// Shared types and constants for the class file stream parser.
// No dependencies; imported by every module of the block.
package cfsp_pkg;

	localparam int CFSP_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_file;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  section;
		logic [4:0]  item_kind;
		logic [31:0] value;
		logic [15:0] entry_index;
		logic [15:0] attr_index;
		logic [1:0]  error;
		logic        last;
	} out_beat_t;

	typedef enum logic [4:0] {
		PH_MAGIC, PH_MINOR, PH_MAJOR, PH_POOLCNT, PH_TAG, PH_UTF8LEN,
		PH_UTF8BYTE, PH_POOLOP, PH_ACCESS, PH_THIS, PH_SUPER, PH_IFCOUNT,
		PH_IFACE, PH_FCOUNT, PH_MACC, PH_MNAME, PH_MDESC, PH_MACNT,
		PH_ANAME, PH_ALEN, PH_ABYTE, PH_MCOUNT, PH_CACOUNT, PH_DONE
	} phase_t;

	localparam logic [2:0] SEC_HEADER  = 3'd0;
	localparam logic [2:0] SEC_POOL    = 3'd1;
	localparam logic [2:0] SEC_CLASS   = 3'd2;
	localparam logic [2:0] SEC_IFACES  = 3'd3;
	localparam logic [2:0] SEC_FIELDS  = 3'd4;
	localparam logic [2:0] SEC_METHODS = 3'd5;
	localparam logic [2:0] SEC_CATTRS  = 3'd6;

	localparam logic [4:0] K_MAGIC     = 5'd0;
	localparam logic [4:0] K_MINOR     = 5'd1;
	localparam logic [4:0] K_MAJOR     = 5'd2;
	localparam logic [4:0] K_POOLCNT   = 5'd3;
	localparam logic [4:0] K_TAG       = 5'd4;
	localparam logic [4:0] K_UTF8LEN   = 5'd5;
	localparam logic [4:0] K_RAW       = 5'd6;
	localparam logic [4:0] K_WORD      = 5'd7;
	localparam logic [4:0] K_INDEX     = 5'd8;
	localparam logic [4:0] K_REFKIND   = 5'd9;
	localparam logic [4:0] K_ACCESS    = 5'd10;
	localparam logic [4:0] K_THIS      = 5'd11;
	localparam logic [4:0] K_SUPER     = 5'd12;
	localparam logic [4:0] K_IFCOUNT   = 5'd13;
	localparam logic [4:0] K_IFACE     = 5'd14;
	localparam logic [4:0] K_FCOUNT    = 5'd15;
	localparam logic [4:0] K_MCOUNT    = 5'd16;
	localparam logic [4:0] K_CACOUNT   = 5'd17;
	localparam logic [4:0] K_MACC      = 5'd18;
	localparam logic [4:0] K_MNAME     = 5'd19;
	localparam logic [4:0] K_MDESC     = 5'd20;
	localparam logic [4:0] K_MACNT     = 5'd21;
	localparam logic [4:0] K_ANAME     = 5'd22;
	localparam logic [4:0] K_ALEN      = 5'd23;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_RESERVED = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

endpackage

### hw/rtl/cfsp_walker.sv
// Front end: byte-wise field walker over the class-file layout.
// Depends on cfsp_pkg; produces at most one result beat per accepted byte.
module cfsp_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  cfsp_pkg::in_beat_t beat,
	output logic              res_valid,
	output cfsp_pkg::out_beat_t res
);
	import cfsp_pkg::*;

	phase_t      phase_q, n_phase;
	logic [1:0]  bp_q, n_bp;
	logic [31:0] acc_q, n_acc, acc_sh, v;
	logic [15:0] pool_left_q, n_pool_left, pool_slot_q, n_pool_slot;
	logic [4:0]  tag_q, n_tag;
	logic [31:0] pay_q, n_pay;
	logic [15:0] list_left_q, n_list_left, list_pos_q, n_list_pos;
	logic [15:0] attrs_left_q, n_attrs_left, attr_pos_q, n_attr_pos;
	logic [1:0]  fault_q, n_fault;
	logic        fin_q, n_fin;
	logic [2:0]  w;
	logic        pe_done, a_done, m_done;
	logic [15:0] used;

	// operand width in bytes of operand ord of a pool entry; 0 ends the entry
	function automatic logic [2:0] op_width(input logic [4:0] tag, input logic [31:0] ord);
		case (tag)
			5'd3, 5'd4:                      op_width = (ord < 32'd1) ? 3'd4 : 3'd0;
			5'd5, 5'd6:                      op_width = (ord < 32'd2) ? 3'd4 : 3'd0;
			5'd7, 5'd8, 5'd16, 5'd19, 5'd20: op_width = (ord < 32'd1) ? 3'd2 : 3'd0;
			5'd9, 5'd10, 5'd11, 5'd12, 5'd17, 5'd18:
			                                 op_width = (ord < 32'd2) ? 3'd2 : 3'd0;
			5'd15: op_width = (ord == 32'd0) ? 3'd1 : ((ord == 32'd1) ? 3'd2 : 3'd0);
			default:                         op_width = 3'd0;
		endcase
	endfunction

	always_comb begin
		n_phase = phase_q; n_bp = bp_q; n_acc = acc_q; n_pool_left = pool_left_q;
		n_pool_slot = pool_slot_q; n_tag = tag_q; n_pay = pay_q;
		n_list_left = list_left_q; n_list_pos = list_pos_q;
		n_attrs_left = attrs_left_q; n_attr_pos = attr_pos_q;
		n_fault = fault_q; n_fin = fin_q;
		res_valid = 1'b0; res = '0;
		w = 3'd2; v = '0; acc_sh = '0; used = 16'd1;
		pe_done = 1'b0; a_done = 1'b0; m_done = 1'b0;
		if (take) begin
			if (beat.new_file) begin
				n_phase = PH_MAGIC; n_bp = '0; n_acc = '0; n_pool_left = '0;
				n_pool_slot = '0; n_tag = '0; n_pay = '0; n_list_left = '0;
				n_list_pos = '0; n_attrs_left = '0; n_attr_pos = '0;
				n_fault = '0; n_fin = 1'b0;
			end
			if (n_fin || n_phase == PH_DONE) begin
				res_valid = 1'b0;
			end else if (n_fault != ERR_NONE) begin
				res_valid = 1'b1;
				res.section = SEC_POOL; res.item_kind = K_RAW;
				res.value = {24'd0, beat.in_byte};
				res.entry_index = n_pool_slot; res.error = n_fault;
			end else begin
				case (n_phase)
					PH_MAGIC, PH_ALEN:              w = 3'd4;
					PH_TAG, PH_UTF8BYTE, PH_ABYTE:  w = 3'd1;
					PH_POOLOP: begin
						w = op_width(n_tag, n_pay);
						if (w == 3'd0) w = 3'd1;
					end
					default:                        w = 3'd2;
				endcase
				acc_sh = {n_acc[23:0], beat.in_byte};
				n_acc = acc_sh;
				if ({1'b0, n_bp} + 3'd1 < w) begin
					n_bp = n_bp + 2'd1;
				end else begin
					n_bp = '0;
					v = acc_sh;
					n_acc = '0;
					res_valid = 1'b1;
					res.value = v;
					case (n_phase)
						PH_MAGIC: begin res.item_kind = K_MAGIC; n_phase = PH_MINOR; end
						PH_MINOR: begin res.item_kind = K_MINOR; n_phase = PH_MAJOR; end
						PH_MAJOR: begin res.item_kind = K_MAJOR; n_phase = PH_POOLCNT; end
						PH_POOLCNT: begin
							res.section = SEC_POOL; res.item_kind = K_POOLCNT;
							n_pool_left = (v != 0) ? v[15:0] - 16'd1 : 16'd0;
							n_pool_slot = 16'd1;
							n_phase = (n_pool_left != 0) ? PH_TAG : PH_ACCESS;
						end
						PH_TAG: begin
							res.section = SEC_POOL; res.item_kind = K_TAG;
							res.entry_index = n_pool_slot;
							n_tag = v[4:0];
							n_pay = '0;
							if (v == 32'd2 || v == 32'd13 || v == 32'd14 || v == 32'd21) begin
								n_fault = ERR_RESERVED; res.error = ERR_RESERVED; n_tag = '0;
							end else if (v == 32'd1) begin
								n_phase = PH_UTF8LEN;
							end else if (op_width(v[4:0], 32'd0) != 3'd0 && v[7:5] == 3'd0) begin
								n_phase = PH_POOLOP;
							end else begin
								n_fault = ERR_UNKNOWN; res.error = ERR_UNKNOWN; n_tag = '0;
							end
						end
						PH_UTF8LEN: begin
							res.section = SEC_POOL; res.item_kind = K_UTF8LEN;
							res.entry_index = n_pool_slot;
							n_pay = v;
							if (v != 0) n_phase = PH_UTF8BYTE; else pe_done = 1'b1;
						end
						PH_UTF8BYTE: begin
							res.section = SEC_POOL; res.item_kind = K_RAW;
							res.entry_index = n_pool_slot;
							n_pay = n_pay - 32'd1;
							if (n_pay == 0) pe_done = 1'b1;
						end
						PH_POOLOP: begin
							res.section = SEC_POOL; res.entry_index = n_pool_slot;
							res.item_kind = (w == 3'd4) ? K_WORD :
								((w == 3'd2) ? K_INDEX : K_REFKIND);
							n_pay = n_pay + 32'd1;
							if (op_width(n_tag, n_pay) == 3'd0) pe_done = 1'b1;
						end
						PH_ACCESS: begin
							res.section = SEC_CLASS; res.item_kind = K_ACCESS; n_phase = PH_THIS;
						end
						PH_THIS: begin
							res.section = SEC_CLASS; res.item_kind = K_THIS; n_phase = PH_SUPER;
						end
						PH_SUPER: begin
							res.section = SEC_CLASS; res.item_kind = K_SUPER;
							n_phase = PH_IFCOUNT;
						end
						PH_IFCOUNT: begin
							res.section = SEC_IFACES; res.item_kind = K_IFCOUNT;
							n_list_left = v[15:0]; n_list_pos = '0;
							n_phase = (n_list_left != 0) ? PH_IFACE : PH_FCOUNT;
						end
						PH_IFACE: begin
							res.section = SEC_IFACES; res.item_kind = K_IFACE;
							res.entry_index = n_list_pos;
							n_list_pos = n_list_pos + 16'd1;
							n_list_left = n_list_left - 16'd1;
							if (n_list_left == 0) n_phase = PH_FCOUNT;
						end
						PH_FCOUNT, PH_MCOUNT: begin
							n_tag = (n_phase == PH_FCOUNT) ? 5'd4 : 5'd5;
							res.section = n_tag[2:0];
							res.item_kind = (n_phase == PH_FCOUNT) ? K_FCOUNT : K_MCOUNT;
							n_list_left = v[15:0]; n_list_pos = '0;
							if (n_list_left != 0) n_phase = PH_MACC;
							else n_phase = (n_tag == 5'd4) ? PH_MCOUNT : PH_CACOUNT;
						end
						PH_MACC: begin
							res.section = n_tag[2:0]; res.item_kind = K_MACC;
							res.entry_index = n_list_pos; n_phase = PH_MNAME;
						end
						PH_MNAME: begin
							res.section = n_tag[2:0]; res.item_kind = K_MNAME;
							res.entry_index = n_list_pos; n_phase = PH_MDESC;
						end
						PH_MDESC: begin
							res.section = n_tag[2:0]; res.item_kind = K_MDESC;
							res.entry_index = n_list_pos; n_phase = PH_MACNT;
						end
						PH_MACNT: begin
							res.section = n_tag[2:0]; res.item_kind = K_MACNT;
							res.entry_index = n_list_pos;
							n_attrs_left = v[15:0]; n_attr_pos = '0;
							if (n_attrs_left != 0) n_phase = PH_ANAME; else m_done = 1'b1;
						end
						PH_CACOUNT: begin
							n_tag = 5'd6; res.section = SEC_CATTRS; res.item_kind = K_CACOUNT;
							n_attrs_left = v[15:0]; n_attr_pos = '0;
							if (n_attrs_left != 0) n_phase = PH_ANAME;
							else begin n_phase = PH_DONE; n_fin = 1'b1; end
						end
						PH_ANAME: begin
							res.section = n_tag[2:0]; res.item_kind = K_ANAME;
							res.attr_index = n_attr_pos;
							res.entry_index = (n_tag == 5'd6) ? 16'd0 : n_list_pos;
							n_phase = PH_ALEN;
						end
						PH_ALEN: begin
							res.section = n_tag[2:0]; res.item_kind = K_ALEN;
							res.attr_index = n_attr_pos;
							res.entry_index = (n_tag == 5'd6) ? 16'd0 : n_list_pos;
							n_pay = v;
							if (v != 0) n_phase = PH_ABYTE; else a_done = 1'b1;
						end
						PH_ABYTE: begin
							res.section = n_tag[2:0]; res.item_kind = K_RAW;
							res.attr_index = n_attr_pos;
							res.entry_index = (n_tag == 5'd6) ? 16'd0 : n_list_pos;
							n_pay = n_pay - 32'd1;
							if (n_pay == 0) a_done = 1'b1;
						end
						default: res_valid = 1'b0;
					endcase
					// long and double take two pool slots
					if (pe_done) begin
						used = (n_tag == 5'd5 || n_tag == 5'd6) ? 16'd2 : 16'd1;
						n_pool_slot = n_pool_slot + used;
						n_pool_left = (n_pool_left > used) ? n_pool_left - used : 16'd0;
						n_phase = (n_pool_left != 0) ? PH_TAG : PH_ACCESS;
					end
					if (a_done) begin
						n_attr_pos = n_attr_pos + 16'd1;
						n_attrs_left = n_attrs_left - 16'd1;
						if (n_attrs_left != 0) n_phase = PH_ANAME;
						else if (n_tag == 5'd6) begin n_phase = PH_DONE; n_fin = 1'b1; end
						else m_done = 1'b1;
					end
					if (m_done) begin
						n_list_pos = n_list_pos + 16'd1;
						n_list_left = n_list_left - 16'd1;
						if (n_list_left != 0) n_phase = PH_MACC;
						else n_phase = (n_tag == 5'd4) ? PH_MCOUNT : PH_CACOUNT;
					end
					res.last = n_fin;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; bp_q <= '0; acc_q <= '0; pool_left_q <= '0;
			pool_slot_q <= '0; tag_q <= '0; pay_q <= '0; list_left_q <= '0;
			list_pos_q <= '0; attrs_left_q <= '0; attr_pos_q <= '0;
			fault_q <= '0; fin_q <= 1'b0;
		end else begin
			phase_q <= n_phase; bp_q <= n_bp; acc_q <= n_acc;
			pool_left_q <= n_pool_left; pool_slot_q <= n_pool_slot; tag_q <= n_tag;
			pay_q <= n_pay; list_left_q <= n_list_left; list_pos_q <= n_list_pos;
			attrs_left_q <= n_attrs_left; attr_pos_q <= n_attr_pos;
			fault_q <= n_fault; fin_q <= n_fin;
		end
	end
endmodule

### hw/rtl/cfsp_queue.sv
// Short result queue between the walker and the output stage.
// Depends on cfsp_pkg for the result beat type.
module cfsp_queue #(
	parameter int DEPTH = cfsp_pkg::CFSP_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cfsp_pkg::out_beat_t wdata,
	input  logic               pop,
	output cfsp_pkg::out_beat_t rdata,
	output logic               nonempty,
	output logic               full
);
	import cfsp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_beat_t       slots_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == CW'(DEPTH));
	assign rdata    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop)  rd_q <= bump(rd_q);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule

### hw/rtl/cfsp_out_stage.sv
// Back end: output register that drains the queue toward the consumer.
// Depends on cfsp_pkg for the result beat type.
module cfsp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  cfsp_pkg::out_beat_t q_data,
	output logic               q_pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output cfsp_pkg::out_beat_t dst_data
);
	import cfsp_pkg::*;

	logic      valid_q;
	out_beat_t data_q;

	assign q_pop     = q_nonempty && (!valid_q || !dst_stall);
	assign dst_valid = valid_q;
	assign dst_data  = data_q;

	always_ff @(posedge clk) begin
		if (q_pop) data_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (q_pop) valid_q <= 1'b1;
		else if (!dst_stall) valid_q <= 1'b0;
	end
endmodule

### hw/rtl/class_file_stream_parser_top.sv
// Class file stream parser: takes a class file one byte per beat and delivers one
// result beat per completed big-endian field (or raw byte), tagged with section,
// kind, entry and attribute index. A beat is taken every cycle while src_stall is
// low; src_stall rises only when the QUEUE_DEPTH-entry result queue is full, so
// the sustained rate is one byte per cycle as long as the consumer keeps up.
// Each byte is classified and advances the field walker in the cycle it is
// taken; its result is written into the queue at the accepting edge and then
// loaded into the output register that drives dst_data, behind any older
// results and held back while dst_stall is high. Bytes in the middle of a
// multi-byte field and bytes after the file is complete give no result.
// new_file on a beat restarts the walk at that byte.
// Depends on cfsp_pkg, cfsp_walker, cfsp_queue and cfsp_out_stage.
module class_file_stream_parser_top #(
	parameter int QUEUE_DEPTH = cfsp_pkg::CFSP_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  cfsp_pkg::in_beat_t  src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output cfsp_pkg::out_beat_t dst_data
);
	import cfsp_pkg::*;

	logic      take, res_valid, q_full, q_nonempty, q_pop;
	out_beat_t res, q_data;

	// stall is a register-derived full flag, independent of this cycle's beat
	assign src_stall = q_full;
	assign take      = src_valid && !q_full;

	// front: field walker
	cfsp_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.beat      (src_data),
		.res_valid (res_valid),
		.res       (res)
	);

	// decoupling queue
	cfsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.wdata    (res),
		.pop      (q_pop),
		.rdata    (q_data),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	// back: output register
	cfsp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_data   (dst_data)
	);
endmodule

### hw/rtl/cfsp_checker.sv
// Port-level checks for the class file stream parser, bound to the top level.
// Depends on cfsp_pkg and class_file_stream_parser_top.
module cfsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               dst_valid,
	input logic               dst_stall,
	input cfsp_pkg::out_beat_t dst_data
);
	import cfsp_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable(dst_data))
		else $error("stalled result beat changed");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.last |-> dst_data.section == SEC_CATTRS &&
		(dst_data.item_kind == K_CACOUNT || dst_data.item_kind == K_ALEN ||
		 dst_data.item_kind == K_RAW))
		else $error("completion flagged outside class attributes");

	a_err_pool: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.error != ERR_NONE |-> dst_data.section == SEC_POOL &&
		dst_data.last == 1'b0)
		else $error("error reported outside the constant pool");
endmodule

bind class_file_stream_parser_top cfsp_checker u_cfsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_data  (dst_data)
);

### dv/class_file_stream_parser_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for class_file_stream_parser_top: directed table, then random class files.
// Needs cfsp_pkg and the parser RTL; it has its own field-walk predictor.
module class_file_stream_parser_top_test;
	import cfsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_BEATS  = 750;

	typedef struct {
		in_beat_t  b;
		bit        chk;   // typed expectation present
		out_beat_t e;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_beat_t  src_data = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_beat_t dst_data;

	class_file_stream_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data)
	);

	always #4 clk = ~clk;

	// Field results still owed by the parser, oldest first.
	out_beat_t field_q[$];
	int        errors = 0;
	int        beats_sent = 0;
	int        fields_seen = 0;
	int        cycles = 0;

	// Receiver pacing state, shared between the checker and the stall driver.
	int rx_hold = 0;      // long hold-off, in cycles
	int rx_gap = 0;
	bit rx_quiet = 1'b0;  // no random stalls while set
	bit rx_took = 1'b0;
	bit tx_quiet = 1'b0;

	// ---------------------------------------------------------------
	// Walker model: a copy of the parser state, advanced per byte beat.
	// ---------------------------------------------------------------
	phase_t      w_phase;
	logic [1:0]  w_pos;
	logic [31:0] w_acc, w_payload;
	logic [15:0] w_pool_left, w_slot, w_list_left, w_list_pos, w_attrs_left, w_attr_pos;
	logic [4:0]  w_tag;
	logic [1:0]  w_fault;
	logic        w_finished;

	function automatic void walker_clear();
		w_phase = PH_MAGIC; w_pos = '0; w_acc = '0; w_payload = '0;
		w_pool_left = '0; w_slot = '0; w_list_left = '0; w_list_pos = '0;
		w_attrs_left = '0; w_attr_pos = '0; w_tag = '0; w_fault = '0; w_finished = 1'b0;
	endfunction

	// Operand width in bytes for pool tag t, operand ordinal n; 0 ends the entry.
	function automatic int operand_bytes(logic [4:0] t, logic [31:0] n);
		case (t)
			5'd3, 5'd4: return n < 1 ? 4 : 0;
			5'd5, 5'd6: return n < 2 ? 4 : 0;
			5'd7, 5'd8, 5'd16, 5'd19, 5'd20: return n < 1 ? 2 : 0;
			5'd9, 5'd10, 5'd11, 5'd12, 5'd17, 5'd18: return n < 2 ? 2 : 0;
			5'd15: return n == 0 ? 1 : (n == 1 ? 2 : 0);
			default: return 0;
		endcase
	endfunction

	function automatic void pool_entry_end();
		logic [15:0] used;
		used = (w_tag == 5'd5 || w_tag == 5'd6) ? 16'd2 : 16'd1;
		w_slot = w_slot + used;
		w_pool_left = w_pool_left > used ? w_pool_left - used : 16'd0;
		w_phase = w_pool_left != 0 ? PH_TAG : PH_ACCESS;
	endfunction

	function automatic void member_end();
		w_list_pos++;
		w_list_left--;
		if (w_list_left != 0) w_phase = PH_MACC;
		else w_phase = (w_tag == 5'd4) ? PH_MCOUNT : PH_CACOUNT;
	endfunction

	function automatic void attr_end();
		w_attr_pos++;
		w_attrs_left--;
		if (w_attrs_left != 0) w_phase = PH_ANAME;
		else if (w_tag == 5'd6) begin
			w_phase = PH_DONE; w_finished = 1'b1;
		end else member_end();
	endfunction

	// Advance the walker by one byte; returns 1 with the field result if one completes.
	function automatic bit walk_byte(in_beat_t ib, output out_beat_t r);
		int          width;
		logic [31:0] v;
		logic [7:0]  b;
		b = ib.in_byte;
		r = '0;
		if (ib.new_file) walker_clear();
		if (w_finished || w_phase >= PH_DONE) return 0;
		if (w_fault != 0) begin
			r.section = SEC_POOL; r.item_kind = K_RAW; r.value = {24'd0, b};
			r.entry_index = w_slot; r.error = w_fault;
			return 1;
		end
		case (w_phase)
			PH_MAGIC, PH_ALEN: width = 4;
			PH_TAG, PH_UTF8BYTE, PH_ABYTE: width = 1;
			PH_POOLOP: begin
				width = operand_bytes(w_tag, w_payload);
				if (width == 0) width = 1;
			end
			default: width = 2;
		endcase
		w_acc = {w_acc[23:0], b};
		if (int'(w_pos) + 1 < width) begin
			w_pos++;
			return 0;
		end
		w_pos = '0;
		v = w_acc;
		w_acc = '0;
		case (w_phase)
			PH_MAGIC: begin r.item_kind = K_MAGIC; w_phase = PH_MINOR; end
			PH_MINOR: begin r.item_kind = K_MINOR; w_phase = PH_MAJOR; end
			PH_MAJOR: begin r.item_kind = K_MAJOR; w_phase = PH_POOLCNT; end
			PH_POOLCNT: begin
				r.section = SEC_POOL; r.item_kind = K_POOLCNT;
				w_pool_left = v != 0 ? v[15:0] - 16'd1 : 16'd0;
				w_slot = 16'd1;
				w_phase = w_pool_left != 0 ? PH_TAG : PH_ACCESS;
			end
			PH_TAG: begin
				r.section = SEC_POOL; r.item_kind = K_TAG; r.entry_index = w_slot;
				w_tag = v[4:0];
				w_payload = '0;
				if (v == 2 || v == 13 || v == 14 || v == 21) begin
					w_fault = ERR_RESERVED; r.error = ERR_RESERVED; w_tag = '0;
				end else if (v == 1) w_phase = PH_UTF8LEN;
				else if (v < 32 && operand_bytes(v[4:0], 0) != 0) w_phase = PH_POOLOP;
				else begin
					w_fault = ERR_UNKNOWN; r.error = ERR_UNKNOWN; w_tag = '0;
				end
			end
			PH_UTF8LEN: begin
				r.section = SEC_POOL; r.item_kind = K_UTF8LEN; r.entry_index = w_slot;
				w_payload = v;
				if (v != 0) w_phase = PH_UTF8BYTE; else pool_entry_end();
			end
			PH_UTF8BYTE: begin
				r.section = SEC_POOL; r.item_kind = K_RAW; r.entry_index = w_slot;
				w_payload--;
				if (w_payload == 0) pool_entry_end();
			end
			PH_POOLOP: begin
				r.section = SEC_POOL; r.entry_index = w_slot;
				r.item_kind = width == 4 ? K_WORD : (width == 2 ? K_INDEX : K_REFKIND);
				w_payload++;
				if (operand_bytes(w_tag, w_payload) == 0) pool_entry_end();
			end
			PH_ACCESS: begin r.section = SEC_CLASS; r.item_kind = K_ACCESS; w_phase = PH_THIS; end
			PH_THIS:   begin r.section = SEC_CLASS; r.item_kind = K_THIS; w_phase = PH_SUPER; end
			PH_SUPER:  begin r.section = SEC_CLASS; r.item_kind = K_SUPER; w_phase = PH_IFCOUNT; end
			PH_IFCOUNT: begin
				r.section = SEC_IFACES; r.item_kind = K_IFCOUNT;
				w_list_left = v[15:0]; w_list_pos = '0;
				w_phase = w_list_left != 0 ? PH_IFACE : PH_FCOUNT;
			end
			PH_IFACE: begin
				r.section = SEC_IFACES; r.item_kind = K_IFACE; r.entry_index = w_list_pos;
				w_list_pos++; w_list_left--;
				if (w_list_left == 0) w_phase = PH_FCOUNT;
			end
			PH_FCOUNT, PH_MCOUNT: begin
				w_tag = w_phase == PH_FCOUNT ? 5'd4 : 5'd5;
				r.section = w_tag[2:0];
				r.item_kind = w_phase == PH_FCOUNT ? K_FCOUNT : K_MCOUNT;
				w_list_left = v[15:0]; w_list_pos = '0;
				if (w_list_left != 0) w_phase = PH_MACC;
				else w_phase = w_tag == 5'd4 ? PH_MCOUNT : PH_CACOUNT;
			end
			PH_MACC: begin
				r.section = w_tag[2:0]; r.item_kind = K_MACC; r.entry_index = w_list_pos;
				w_phase = PH_MNAME;
			end
			PH_MNAME: begin
				r.section = w_tag[2:0]; r.item_kind = K_MNAME; r.entry_index = w_list_pos;
				w_phase = PH_MDESC;
			end
			PH_MDESC: begin
				r.section = w_tag[2:0]; r.item_kind = K_MDESC; r.entry_index = w_list_pos;
				w_phase = PH_MACNT;
			end
			PH_MACNT: begin
				r.section = w_tag[2:0]; r.item_kind = K_MACNT; r.entry_index = w_list_pos;
				w_attrs_left = v[15:0]; w_attr_pos = '0;
				if (w_attrs_left != 0) w_phase = PH_ANAME; else member_end();
			end
			PH_CACOUNT: begin
				w_tag = 5'd6; r.section = SEC_CATTRS; r.item_kind = K_CACOUNT;
				w_attrs_left = v[15:0]; w_attr_pos = '0;
				if (w_attrs_left != 0) w_phase = PH_ANAME;
				else begin
					w_phase = PH_DONE; w_finished = 1'b1;
				end
			end
			PH_ANAME, PH_ALEN: begin
				r.section = w_tag[2:0]; r.attr_index = w_attr_pos;
				r.entry_index = w_tag == 5'd6 ? 16'd0 : w_list_pos;
				if (w_phase == PH_ANAME) begin
					r.item_kind = K_ANAME; w_phase = PH_ALEN;
				end else begin
					r.item_kind = K_ALEN; w_payload = v;
					if (v != 0) w_phase = PH_ABYTE; else attr_end();
				end
			end
			default: begin // attribute body byte
				r.section = w_tag[2:0]; r.item_kind = K_RAW; r.attr_index = w_attr_pos;
				r.entry_index = w_tag == 5'd6 ? 16'd0 : w_list_pos;
				w_payload--;
				if (w_payload == 0) attr_end();
			end
		endcase
		r.value = v;
		r.last = w_finished;
		return 1;
	endfunction

	// ---------------------------------------------------------------
	// Sender: offer a beat, hold it until taken, then idle gap cycles.
	// ---------------------------------------------------------------
	task automatic send_beat(in_beat_t b, bit chk, out_beat_t typed);
		out_beat_t r;
		bit        st;
		int        gap;
		src_valid <= 1'b1;
		src_data  <= b;
		do begin
			@(negedge clk);
			st = src_stall;
			@(posedge clk);
		end while (st);
		beats_sent++;
		if (walk_byte(b, r)) field_q.push_back(chk ? typed : r);
		else if (chk) field_q.push_back(typed);
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Checker: sample the output side at the falling edge, where it is stable.
	always @(negedge clk) begin
		out_beat_t x;
		if (arst_n && dst_valid && !dst_stall) begin
			rx_took = 1'b1;
			fields_seen++;
			if (field_q.size() == 0) begin
				$error("unexpected field beat %p", dst_data);
				errors++;
			end else begin
				x = field_q.pop_front();
				if (dst_data.section !== x.section) begin
					$error("section: expected %0d, got %0d", x.section, dst_data.section);
					errors++;
				end
				if (dst_data.item_kind !== x.item_kind) begin
					$error("item_kind: expected %0d, got %0d", x.item_kind, dst_data.item_kind);
					errors++;
				end
				if (dst_data.value !== x.value) begin
					$error("value: expected %h, got %h", x.value, dst_data.value);
					errors++;
				end
				if (dst_data.entry_index !== x.entry_index) begin
					$error("entry_index: expected %0d, got %0d", x.entry_index,
						dst_data.entry_index);
					errors++;
				end
				if (dst_data.attr_index !== x.attr_index) begin
					$error("attr_index: expected %0d, got %0d", x.attr_index,
						dst_data.attr_index);
					errors++;
				end
				if (dst_data.error !== x.error) begin
					$error("error: expected %0d, got %0d", x.error, dst_data.error);
					errors++;
				end
				if (dst_data.last !== x.last) begin
					$error("last: expected %0d, got %0d", x.last, dst_data.last);
					errors++;
				end
			end
		end
	end

	// Receiver stall: long hold-off first, else a random wait drawn per taken beat.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			dst_stall <= 1'b1;
			rx_hold--;
		end else begin
			if (rx_gap == 0 && rx_took) begin
				rx_took = 1'b0;
				rx_gap = rx_quiet ? 0 : $urandom_range(0, 7);
			end
			if (rx_gap > 0) begin
				dst_stall <= 1'b1;
				rx_gap--;
			end else begin
				dst_stall <= 1'b0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("class_file_stream_parser_top regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Random class file builder.
	// ---------------------------------------------------------------
	in_beat_t file_q[$];

	function automatic void put8(logic [7:0] v, bit nf = 1'b0);
		in_beat_t b;
		b.in_byte = v;
		b.new_file = nf;
		file_q.push_back(b);
	endfunction

	function automatic void put16(logic [15:0] v);
		put8(v[15:8]); put8(v[7:0]);
	endfunction

	function automatic void put_attrs(int n);
		int len;
		for (int a = 0; a < n; a++) begin
			put16(16'($urandom));
			len = $urandom_range(0, 3);
			put16(16'd0); put16(len[15:0]);
			repeat (len) put8(8'($urandom));
		end
	endfunction

	// One class file, mostly well formed; some are cut short or carry a bad tag.
	function automatic void build_file();
		logic [7:0] good_tags[17] = '{1, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 17, 18, 19, 20};
		logic [7:0] tag;
		int         pc, slot, n, len;
		put8(8'($urandom), 1'b1);
		repeat (3) put8(8'($urandom));
		put16(16'($urandom)); put16(16'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			// truncated file followed by noise
			repeat ($urandom_range(1, 20)) put8(8'($urandom));
			return;
		end
		pc = $urandom_range(0, 6);
		put16(pc[15:0]);
		slot = 1;
		while (slot < pc) begin
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 2))
					0: tag = 8'd2;
					1: tag = $urandom_range(0, 1) ? 8'd13 : ($urandom_range(0, 1) ? 8'd14 : 8'd21);
					default: tag = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(22, 255));
				endcase
				put8(tag);
				repeat ($urandom_range(1, 4)) put8(8'($urandom));
				return;
			end
			tag = good_tags[$urandom_range(0, 16)];
			put8(tag);
			case (tag)
				8'd1: begin
					len = $urandom_range(0, 3);
					put16(len[15:0]);
					repeat (len) put8(8'($urandom));
				end
				8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18:
					repeat (4) put8(8'($urandom));
				8'd5, 8'd6: repeat (8) put8(8'($urandom));
				8'd15: repeat (3) put8(8'($urandom));
				default: repeat (2) put8(8'($urandom));
			endcase
			slot += (tag == 8'd5 || tag == 8'd6) ? 2 : 1;
		end
		repeat (3) put16(16'($urandom));
		n = $urandom_range(0, 2);
		put16(n[15:0]);
		repeat (n) put16(16'($urandom));
		repeat (2) begin
			n = $urandom_range(0, 2);
			put16(n[15:0]);
			repeat (n) begin
				repeat (3) put16(16'($urandom));
				len = $urandom_range(0, 2);
				put16(len[15:0]);
				put_attrs(len);
			end
		end
		n = $urandom_range(0, 2);
		put16(n[15:0]);
		put_attrs(n);
		repeat ($urandom_range(0, 2)) put8(8'($urandom));
	endfunction

	function automatic stim_row_t row(logic [7:0] v, bit nf);
		stim_row_t s;
		s.b.in_byte = v; s.b.new_file = nf; s.chk = 1'b0; s.e = '0;
		return s;
	endfunction

	function automatic stim_row_t row_exp(logic [7:0] v, bit nf, logic [2:0] sec,
			logic [4:0] kind, logic [31:0] val, logic [15:0] ent, logic [1:0] err, bit lst);
		stim_row_t s;
		s = row(v, nf);
		s.chk = 1'b1;
		s.e.section = sec; s.e.item_kind = kind; s.e.value = val;
		s.e.entry_index = ent; s.e.attr_index = '0; s.e.error = err; s.e.last = lst;
		return s;
	endfunction

	stim_row_t table_q[$];

	initial begin
		int files;
		walker_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest complete file: extreme header values, empty pool and lists.
		table_q.push_back(row(8'hCA, 1'b1));
		table_q.push_back(row(8'hFE, 1'b0));
		table_q.push_back(row(8'hBA, 1'b0));
		table_q.push_back(row_exp(8'hBE, 0, SEC_HEADER, K_MAGIC, 32'hCAFEBABE, 0, ERR_NONE, 0));
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row_exp(8'h00, 0, SEC_HEADER, K_MINOR, 32'h0, 0, ERR_NONE, 0));
		table_q.push_back(row(8'hFF, 1'b0));
		table_q.push_back(row_exp(8'hFF, 0, SEC_HEADER, K_MAJOR, 32'hFFFF, 0, ERR_NONE, 0));
		// pool count zero means an empty pool
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row_exp(8'h00, 0, SEC_POOL, K_POOLCNT, 32'h0, 0, ERR_NONE, 0));
		table_q.push_back(row(8'hFF, 1'b0));
		table_q.push_back(row(8'hFF, 1'b0));
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row(8'h01, 1'b0));
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row(8'h02, 1'b0));
		repeat (6) table_q.push_back(row(8'h00, 1'b0));   // empty interfaces, fields, methods
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row_exp(8'h00, 0, SEC_CATTRS, K_CACOUNT, 32'h0, 0, ERR_NONE, 1));
		table_q.push_back(row(8'h55, 1'b0));   // trailing byte, ignored
		// Reserved tag in slot 1, then the sticky fault echo.
		table_q.push_back(row(8'h00, 1'b1));
		repeat (6) table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row(8'h00, 1'b0));
		table_q.push_back(row(8'h03, 1'b0));
		table_q.push_back(row_exp(8'h02, 0, SEC_POOL, K_TAG, 32'h2, 1, ERR_RESERVED, 0));
		table_q.push_back(row_exp(8'hA5, 0, SEC_POOL, K_RAW, 32'hA5, 1, ERR_RESERVED, 0));

		foreach (table_q[i]) send_beat(table_q[i].b, table_q[i].chk, table_q[i].e);

		files = 0;
		while (beats_sent < RAND_BEATS + table_q.size()) begin
			file_q.delete();
			build_file();
			files++;
			tx_quiet = $urandom_range(0, 3) == 0;
			rx_quiet = $urandom_range(0, 3) == 0;
			if (files == 4) begin
				// receiver holds off while the sender keeps pushing: queue fills
				tx_quiet = 1'b1;
				rx_hold = 300;
			end
			if (files == 9) begin
				// sender pauses until every owed field has come out
				src_valid <= 1'b0;
				while (field_q.size() != 0) @(posedge clk);
			end
			foreach (file_q[i]) send_beat(file_q[i], 1'b0, '0);
		end
		src_valid <= 1'b0;

		while (field_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d byte beats over %0d random files, %0d field beats checked",
			beats_sent, files, fields_seen);
		if (errors == 0 && field_q.size() == 0)
			$display("class_file_stream_parser_top regression: pass");
		else
			$display("class_file_stream_parser_top regression: fail");
		$finish;
	end

endmodule
